@@ design/hsvca_pkg.sv @@
package hsvca_pkg;

    localparam int PIX_BITS = 8;
    localparam int LIMIT_BITS = 22;
    localparam int CLASS_BITS = 2;
    localparam int CFG_INDEX_BITS = 8;
    localparam int HUE_BITS = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_LIMIT = 8'd1;

    localparam logic [LIMIT_BITS-1:0] RED_LIMIT_RESET = 22'd500;
    localparam logic [LIMIT_BITS-1:0] BLUE_LIMIT_RESET = 22'd200;

    localparam logic [CLASS_BITS-1:0] CLASS_SAFE = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_RED = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_BLUE = 2'd2;

    localparam logic [7:0] RED_SAT_MIN = 8'd120;
    localparam logic [7:0] RED_VAL_MIN = 8'd70;
    localparam logic [7:0] RED_HUE_LOW_MAX = 8'd10;
    localparam logic [7:0] RED_HUE_HIGH_MIN = 8'd170;
    localparam logic [7:0] RED_HUE_HIGH_MAX = 8'd180;
    localparam logic [7:0] BLUE_SAT_MIN = 8'd150;
    localparam logic [7:0] BLUE_HUE_MIN = 8'd100;
    localparam logic [7:0] BLUE_HUE_MAX = 8'd140;
    localparam logic [7:0] HUE_WRAP = 8'd180;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a pixel into stage one
        logic advance;   // move stage one results into the count stage
        logic classify;  // frame ends in the count stage: emit class, clear counts
    } hsvca_cmd_t;

    typedef struct packed {
        logic out_full;
    } hsvca_status_t;

endpackage

@@ design/hsvca_datapath.sv @@
module hsvca_datapath #(
    parameter int COUNT_BITS = 22
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hsvca_pkg::hsvca_cmd_t               cmd,
    input  logic [hsvca_pkg::PIX_BITS-1:0]      blue_level,
    input  logic [hsvca_pkg::PIX_BITS-1:0]      green_level,
    input  logic [hsvca_pkg::PIX_BITS-1:0]      red_level,
    input  logic                                frame_end,
    input  logic [hsvca_pkg::LIMIT_BITS-1:0]    red_limit,
    input  logic [hsvca_pkg::LIMIT_BITS-1:0]    blue_limit,
    output logic [hsvca_pkg::CLASS_BITS-1:0]    frame_class
);

    // Hue is the quotient q = floor(hnum / hden) shifted by -30 plus the source base.
    // With red as the source, h = q - 30 wrapped by 180, so both red bands form one
    // range of q. With blue as the source, h = q + 90. With green as the source,
    // h stays in 30..90 and hits neither color.
    localparam int HUE_OFS = 30;
    localparam int BLUE_BASE = 120;
    localparam logic [15:0] RED_Q_LO =
        16'(int'(hsvca_pkg::RED_HUE_HIGH_MIN) - int'(hsvca_pkg::HUE_WRAP) + HUE_OFS);
    localparam logic [15:0] RED_Q_END =
        16'(int'(hsvca_pkg::RED_HUE_LOW_MAX) + HUE_OFS + 1);
    localparam logic [15:0] BLUE_Q_LO =
        16'(int'(hsvca_pkg::BLUE_HUE_MIN) - BLUE_BASE + HUE_OFS);
    localparam logic [15:0] BLUE_Q_END =
        16'(int'(hsvca_pkg::BLUE_HUE_MAX) - BLUE_BASE + HUE_OFS + 1);

    // Stage one: min, max and the numerators. Each color test compares a numerator
    // against a constant multiple of its denominator, so no quotient is formed.
    logic [7:0]  mx, mn, diff;
    logic signed [9:0] delta;
    logic        src_red, src_blue;
    logic [17:0] snum;
    logic [16:0] sden;
    logic [15:0] hnum;
    logic [8:0]  hden;
    logic        sat_red_ok, sat_blue_ok, hue_red_ok, hue_blue_ok;

    always_comb begin
        mx = red_level;
        mn = red_level;
        if (green_level > mx) mx = green_level;
        if (blue_level > mx) mx = blue_level;
        if (green_level < mn) mn = green_level;
        if (blue_level < mn) mn = blue_level;
        diff = mx - mn;
        src_red = (mx == red_level);
        src_blue = !src_red && (mx != green_level);
        if (src_red) begin
            delta = 10'($signed({2'b0, green_level})) - 10'($signed({2'b0, blue_level}));
        end else if (mx == green_level) begin
            delta = 10'($signed({2'b0, blue_level})) - 10'($signed({2'b0, red_level}));
        end else begin
            delta = 10'($signed({2'b0, red_level})) - 10'($signed({2'b0, green_level}));
        end
        snum = 18'(510 * diff) + 18'(mx);
        sden = {8'd0, mx, 1'b0};
        sat_red_ok = (mx != 8'd0) && (snum >= 18'(sden) * 18'(hsvca_pkg::RED_SAT_MIN));
        sat_blue_ok = (mx != 8'd0) && (snum >= 18'(sden) * 18'(hsvca_pkg::BLUE_SAT_MIN));
        // Hue numerator is in 0..121*diff, quotient in 0..60.
        hnum = 16'($signed(16'(60) * 16'($signed(delta))) + 16'(61 * diff));
        hden = {diff, 1'b0};
        // A grey pixel has hue zero, which lies in the low red band.
        hue_red_ok = (diff == 8'd0) || (src_red && (hnum >= 16'(hden) * RED_Q_LO)
            && (hnum < 16'(hden) * RED_Q_END));
        hue_blue_ok = (diff != 8'd0) && src_blue && (hnum >= 16'(hden) * BLUE_Q_LO)
            && (hnum < 16'(hden) * BLUE_Q_END);
    end

    logic red_px_reg, blue_px_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_px_reg <= sat_red_ok && (mx >= hsvca_pkg::RED_VAL_MIN) && hue_red_ok;
            blue_px_reg <= sat_blue_ok && hue_blue_ok;
            last_reg <= frame_end;
        end
    end

    // Count stage.
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    logic [COUNT_BITS-1:0] red_cnt_reg, red_cnt_next, blue_cnt_reg, blue_cnt_next;
    logic [hsvca_pkg::CLASS_BITS-1:0] class_reg;

    always_comb begin
        red_cnt_next = red_cnt_reg;
        blue_cnt_next = blue_cnt_reg;
        if (red_px_reg && red_cnt_reg != CNT_MAX) red_cnt_next = red_cnt_reg + 1'b1;
        if (blue_px_reg && blue_cnt_reg != CNT_MAX) blue_cnt_next = blue_cnt_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_cnt_reg <= '0;
            blue_cnt_reg <= '0;
        end else if (cmd.advance) begin
            if (last_reg) begin
                red_cnt_reg <= '0;
                blue_cnt_reg <= '0;
            end else begin
                red_cnt_reg <= red_cnt_next;
                blue_cnt_reg <= blue_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.classify) begin
            if (33'(red_cnt_next) > 33'(red_limit))
                class_reg <= hsvca_pkg::CLASS_RED;
            else if (33'(blue_cnt_next) > 33'(blue_limit))
                class_reg <= hsvca_pkg::CLASS_BLUE;
            else
                class_reg <= hsvca_pkg::CLASS_SAFE;
        end
    end

    assign frame_class = class_reg;

endmodule

@@ design/hsvca_ctrl.sv @@
module hsvca_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output hsvca_pkg::hsvca_cmd_t   cmd
);

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_PIXEL = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;

    // State tracks what stage one holds: nothing, a mid-frame pixel or a last pixel.
    logic [1:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic s_fire, out_free;

    assign out_free = !out_valid_reg || m_tready;
    // A last pixel in stage one can leave only when the output slot is free.
    always_comb begin
        cmd.advance = 1'b0;
        cmd.classify = 1'b0;
        case (state_reg)
            ST_EMPTY: ;
            ST_PIXEL: cmd.advance = 1'b1;
            ST_LAST: begin
                cmd.advance = out_free;
                cmd.classify = out_free;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg != ST_LAST) || out_free;
    assign s_fire = s_tvalid && s_tready;
    assign cmd.load = s_fire;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        if (s_fire) state_next = s_tlast ? ST_LAST : ST_PIXEL;
        else if (cmd.advance) state_next = ST_EMPTY;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        if (cmd.classify) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/hsv_color_area_classifier.sv @@
// One BGR pixel is accepted per clock while the input is not stalled; the HSV color
// tests are registered at the pixel transfer and the counts are updated from those
// registered results, so m_tvalid rises once the class register has been loaded from the
// frame's last pixel. Input stalls only while a frame class waits in the output register
// and another last pixel is ready to be classified. Limits are written through cfg_*.
module hsv_color_area_classifier #(
    parameter int COUNT_BITS = 22
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue_level[7:0], green_level[15:8], red_level[23:16]
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_class[1:0], zero fill above
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [hsvca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    hsvca_pkg::hsvca_cmd_t cmd;
    logic [hsvca_pkg::LIMIT_BITS-1:0] red_limit_reg, blue_limit_reg;
    logic [hsvca_pkg::CLASS_BITS-1:0] frame_class;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_limit_reg <= hsvca_pkg::RED_LIMIT_RESET;
            blue_limit_reg <= hsvca_pkg::BLUE_LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == hsvca_pkg::REG_RED_LIMIT)
                red_limit_reg <= cfg_data[hsvca_pkg::LIMIT_BITS-1:0];
            else if (cfg_index == hsvca_pkg::REG_BLUE_LIMIT)
                blue_limit_reg <= cfg_data[hsvca_pkg::LIMIT_BITS-1:0];
        end
    end

    hsvca_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd)
    );

    hsvca_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .blue_level(s_tdata[7:0]), .green_level(s_tdata[15:8]),
        .red_level(s_tdata[23:16]), .frame_end(s_tlast),
        .red_limit(red_limit_reg), .blue_limit(blue_limit_reg),
        .frame_class(frame_class)
    );

    assign m_tdata = {6'd0, frame_class};

endmodule

@@ design/hsvca_checker.sv @@
module hsvca_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[7:2] == 6'd0))
        else $error("frame class out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_result_without_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without frame end");

    a_ready_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind hsv_color_area_classifier hsvca_checker u_hsvca_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
